@@ rtl/core/text_console_with_escapes_assert.svh @@
// Assertion macros used by the console back end (tcon_back)
`ifndef TEXT_CONSOLE_WITH_ESCAPES_ASSERT_SVH
`define TEXT_CONSOLE_WITH_ESCAPES_ASSERT_SVH

`ifndef ASSERT_OFF
`define TCON_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCON_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCON_ASSERT(lbl, prop, msg)
`define TCON_ASSERT_NR(lbl, prop, msg)
`endif

`endif

@@ rtl/core/tcon_pkg.sv @@
`timescale 1ns / 1ps
package tcon_pkg;

  localparam int COLUMNS  = 80;
  localparam int LINES    = 25;
  localparam int TAB_STEP = 8;
  localparam int CELLS    = COLUMNS * LINES;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CLR_W  = 3;
  localparam int CHR_W  = 8;
  localparam int CELL_W = CHR_W + CLR_W;
  localparam int NUM_W  = 7;

  localparam logic [CLR_W-1:0] DEFAULT_COLOR_RST = 3'd7;
  localparam logic [CLR_W-1:0] CLEAR_COLOR_RST   = 3'd2;
  localparam logic [CLR_W-1:0] PEN_RED           = 3'd4;
  localparam logic [CLR_W-1:0] PEN_GREEN         = 3'd2;

  localparam logic [CHR_W-1:0] CH_NUL    = 8'd0;
  localparam logic [CHR_W-1:0] CH_BS     = 8'd8;
  localparam logic [CHR_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CHR_W-1:0] CH_LF     = 8'd10;
  localparam logic [CHR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHR_W-1:0] CH_ESC    = 8'd27;
  localparam logic [CHR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHR_W-1:0] CH_J      = 8'h4A;
  localparam logic [CHR_W-1:0] CH_M      = 8'h6D;
  localparam logic [CHR_W-1:0] CH_H      = 8'h48;
  localparam logic [CHR_W-1:0] CH_F      = 8'h66;

  localparam logic [0:0] REG_DEFAULT_COLOR = 1'b0;
  localparam logic [0:0] REG_CLEAR_COLOR   = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP, OP_READ, OP_PRINT, OP_TAB, OP_CR, OP_LF, OP_BS, OP_CLEAR, OP_COLOR, OP_MOVE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [CHR_W-1:0] chr;
    logic [CLR_W-1:0] color;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ADDR_W-1:0] idx;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    logic [ADDR_W+1:0] a;
    a = (ADDR_W+2)'(row) * (ADDR_W+2)'(COLUMNS) + (ADDR_W+2)'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

@@ rtl/core/tcon_in_if.sv @@
`timescale 1ns / 1ps
interface tcon_in_if import tcon_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHR_W-1:0]  char_byte;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, kind, char_byte, cell_index, input ready);
  modport sink   (input valid, kind, char_byte, cell_index, output ready);
endinterface

@@ rtl/core/tcon_out_if.sv @@
`timescale 1ns / 1ps
interface tcon_out_if import tcon_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHR_W-1:0]  cell_char;
  logic [CLR_W-1:0]  cell_color;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_addr;

  modport source (output valid, cell_char, cell_color, cursor_col, cursor_row, cursor_addr,
                  input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_col, cursor_row, cursor_addr,
                  output ready);
endinterface

@@ rtl/core/text_console_with_escapes.sv @@
`timescale 1ns / 1ps
// Text console, 80x25 cells of character plus 3-bit color, with a small ANSI
// escape parser (ESC[2J, ESC[n m, ESC[r;cH/f). A front parser accepts one item
// per cycle while the two-entry command queue has room; the back end executes
// one command per cycle on the single-write-port cell memory while idle and
// the output is not stalled, so printable and control bytes sustain one item
// per cycle; a cell read waits in a read state (registered memory read). A line
// feed on the last row (scroll) or ESC[2J (clear) walks the whole memory, one
// cell per cycle, and stalls the stream. After reset a clearing pass runs before
// items are executed; configuration writes are taken at any time.
module text_console_with_escapes import tcon_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CLR_W-1:0] cfg_wdata,
  tcon_in_if.sink          in_ch,
  tcon_out_if.source       out_ch
);
  logic [CLR_W-1:0] default_color_r, clear_color_r;
  cmd_t             f_cmd, b_cmd;
  logic             f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_color_r <= DEFAULT_COLOR_RST;
      clear_color_r   <= CLEAR_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_COLOR: default_color_r <= cfg_wdata;
        REG_CLEAR_COLOR:   clear_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcon_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .default_color (default_color_r),
    .cmd           (f_cmd),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready)
  );

  tcon_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (b_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  tcon_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (b_cmd),
    .cmd_valid   (b_valid),
    .cmd_ready   (b_ready),
    .clear_color (clear_color_r),
    .out_ch      (out_ch)
  );
endmodule

@@ rtl/core/tcon_ram.sv @@
`timescale 1ns / 1ps
module tcon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/tcon_front.sv @@
`timescale 1ns / 1ps
module tcon_front import tcon_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  tcon_in_if.sink          in_ch,
  input  logic [CLR_W-1:0] default_color,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  logic             cmd_ready
);
  typedef enum logic [2:0] {
    PH_TEXT, PH_ESC, PH_BRACKET, PH_N1A, PH_N1B, PH_SEMI, PH_N2A, PH_N2B
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [NUM_W-1:0] fn_r, fn_nxt, sn_r, sn_nxt;
  logic [CHR_W-1:0] b;
  logic [3:0]       dig;
  logic             is_dig, end1, end2, abort_p;
  logic [NUM_W-1:0] r1, c1;

  assign b         = in_ch.char_byte;
  assign is_dig    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dig       = 4'(b - CH_ZERO);
  assign cmd_valid = in_ch.valid;
  assign in_ch.ready = cmd_ready;
  assign r1 = (fn_r == '0) ? NUM_W'(1) : fn_r;
  assign c1 = (sn_r == '0) ? NUM_W'(1) : sn_r;

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NOP;
    cmd.chr   = b;
    cmd.idx   = in_ch.cell_index;
    phase_nxt = phase_r;
    fn_nxt    = fn_r;
    sn_nxt    = sn_r;
    end1      = 1'b0;
    end2      = 1'b0;
    abort_p   = 1'b0;
    if (in_ch.kind) begin
      cmd.op = OP_READ;
    end else if (b != CH_NUL) begin
      case (phase_r)
        PH_ESC: begin
          if (b == CH_LBRACK) phase_nxt = PH_BRACKET;
          else abort_p = 1'b1;
        end
        PH_BRACKET: begin
          if (is_dig) begin
            fn_nxt    = NUM_W'(dig);
            phase_nxt = PH_N1A;
          end else abort_p = 1'b1;
        end
        PH_N1A: begin
          if (is_dig) begin
            fn_nxt    = NUM_W'(fn_r * 10 + NUM_W'(dig));
            phase_nxt = PH_N1B;
          end else end1 = 1'b1;
        end
        PH_N1B: end1 = 1'b1;
        PH_SEMI: begin
          if (is_dig) begin
            sn_nxt    = NUM_W'(dig);
            phase_nxt = PH_N2A;
          end else abort_p = 1'b1;
        end
        PH_N2A: begin
          if (is_dig) begin
            sn_nxt    = NUM_W'(sn_r * 10 + NUM_W'(dig));
            phase_nxt = PH_N2B;
          end else end2 = 1'b1;
        end
        PH_N2B: end2 = 1'b1;
        default: abort_p = 1'b1;
      endcase
      if (end1) begin
        if (b == CH_J) begin
          if (fn_r == NUM_W'(2)) cmd.op = OP_CLEAR;
          phase_nxt = PH_TEXT;
        end else if (b == CH_M) begin
          if (fn_r == NUM_W'(31)) begin
            cmd.op = OP_COLOR; cmd.color = PEN_RED;
          end else if (fn_r == NUM_W'(32)) begin
            cmd.op = OP_COLOR; cmd.color = PEN_GREEN;
          end else if (fn_r == NUM_W'(37) || fn_r == NUM_W'(39)) begin
            cmd.op = OP_COLOR; cmd.color = default_color;
          end
          phase_nxt = PH_TEXT;
        end else if (b == CH_SEMI) begin
          phase_nxt = PH_SEMI;
        end else abort_p = 1'b1;
      end
      if (end2) begin
        if (b == CH_H || b == CH_F) begin
          if (c1 <= NUM_W'(COLUMNS) && r1 <= NUM_W'(LINES)) begin
            cmd.op  = OP_MOVE;
            cmd.row = ROW_W'(r1 - 1'b1);
            cmd.col = COL_W'(c1 - 1'b1);
          end
          phase_nxt = PH_TEXT;
        end else abort_p = 1'b1;
      end
      if (abort_p) begin
        phase_nxt = PH_TEXT;
        case (b)
          CH_ESC:  phase_nxt = PH_ESC;
          CH_TAB:  cmd.op = OP_TAB;
          CH_CR:   cmd.op = OP_CR;
          CH_LF:   cmd.op = OP_LF;
          CH_BS:   cmd.op = OP_BS;
          default: cmd.op = OP_PRINT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      fn_r    <= '0;
      sn_r    <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      phase_r <= phase_nxt;
      fn_r    <= fn_nxt;
      sn_r    <= sn_nxt;
    end
  end
endmodule

@@ rtl/core/tcon_fifo.sv @@
`timescale 1ns / 1ps
module tcon_fifo import tcon_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);
  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = ent_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ rtl/core/tcon_back.sv @@
`timescale 1ns / 1ps
`include "text_console_with_escapes_assert.svh"
module tcon_back import tcon_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic [CLR_W-1:0] clear_color,
  tcon_out_if.source       out_ch
);
  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_READ} state_t;

  state_t            state_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CLR_W-1:0]  color_r, color_nxt;
  logic [ADDR_W-1:0] cnt_r, waddr_r;
  logic [CELL_W-1:0] fill_r;
  logic              scroll_r, wpend_r, wram_r, rd_ok_r;
  logic              out_valid_r;
  logic [CHR_W-1:0]  out_chr_r;
  logic [CLR_W-1:0]  out_clr_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              take, idle_we, lf, go_scroll, go_clear, shift_src;
  logic [ADDR_W-1:0] idle_addr, cur_addr, raddr, waddr;
  logic [CELL_W-1:0] idle_data, wdata, rdata;
  logic [COL_W:0]    t;

  assign cur_addr  = cell_addr(row_r, col_r);
  assign cmd_ready = (state_r == ST_IDLE) && !wpend_r && (!out_valid_r || out_ch.ready);
  assign take      = cmd_ready && cmd_valid;
  assign shift_src = scroll_r && (cnt_r < ADDR_W'(CELLS - COLUMNS));

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    color_nxt = color_r;
    idle_we   = 1'b0;
    idle_addr = cur_addr;
    idle_data = {cmd.chr, color_r};
    lf        = 1'b0;
    go_scroll = 1'b0;
    go_clear  = 1'b0;
    t         = '0;
    case (cmd.op)
      OP_PRINT: begin
        idle_we = 1'b1;
        t       = (COL_W+1)'(col_r) + 1'b1;
        col_nxt = t[COL_W-1:0];
        if (t >= (COL_W+1)'(COLUMNS)) lf = 1'b1;
      end
      OP_TAB: begin
        t       = (COL_W+1)'((col_r / TAB_STEP + 1) * TAB_STEP);
        col_nxt = t[COL_W-1:0];
        if (t >= (COL_W+1)'(COLUMNS)) lf = 1'b1;
      end
      OP_CR: col_nxt = '0;
      OP_LF: lf = 1'b1;
      OP_BS: begin
        if (col_r != '0) begin
          col_nxt   = col_r - 1'b1;
          idle_we   = 1'b1;
          idle_addr = cur_addr - 1'b1;
          idle_data = {CH_SPACE, color_r};
        end
      end
      OP_CLEAR: begin
        col_nxt  = '0;
        row_nxt  = '0;
        go_clear = 1'b1;
      end
      OP_COLOR: color_nxt = cmd.color;
      OP_MOVE: begin
        col_nxt = cmd.col;
        row_nxt = cmd.row;
      end
      default: ;
    endcase
    if (lf) begin
      col_nxt = '0;
      if (row_r < ROW_W'(LINES - 1)) row_nxt = row_r + 1'b1;
      else go_scroll = 1'b1;
    end
  end

  // while scrolling, the sweep reads one line ahead and writes the row above in the next cycle; a clear writes the fill
  always_comb begin
    if (state_r == ST_SWEEP) raddr = shift_src ? cnt_r + ADDR_W'(COLUMNS) : '0;
    else raddr = (cmd.idx < ADDR_W'(CELLS)) ? cmd.idx : '0;
    waddr = wpend_r ? waddr_r : idle_addr;
    wdata = wpend_r ? (wram_r ? rdata : fill_r) : idle_data;
  end

  tcon_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (wpend_r || (take && idle_we)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cnt_r       <= '0;
      fill_r      <= {CH_NUL, CLEAR_COLOR_RST};
      scroll_r    <= 1'b0;
      wpend_r     <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      color_r     <= DEFAULT_COLOR_RST;
      out_valid_r <= 1'b0;
    end else begin
      wpend_r <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_SWEEP: begin
          wpend_r <= 1'b1;
          waddr_r <= cnt_r;
          wram_r  <= shift_src;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == ADDR_W'(CELLS - 1)) state_r <= ST_IDLE;
        end
        ST_READ: begin
          out_valid_r <= 1'b1;
          out_chr_r   <= rd_ok_r ? rdata[CELL_W-1:CLR_W] : '0;
          out_clr_r   <= rd_ok_r ? rdata[CLR_W-1:0] : '0;
          state_r     <= ST_IDLE;
        end
        default: begin
          if (take) begin
            col_r   <= col_nxt;
            row_r   <= row_nxt;
            color_r <= color_nxt;
            rd_ok_r <= cmd.idx < ADDR_W'(CELLS);
            out_col_r  <= col_nxt;
            out_row_r  <= row_nxt;
            out_addr_r <= cell_addr(row_nxt, col_nxt);
            out_chr_r  <= '0;
            out_clr_r  <= '0;
            if (cmd.op == OP_READ) begin
              state_r <= ST_READ;
            end else begin
              out_valid_r <= 1'b1;
            end
            if (go_scroll || go_clear) begin
              state_r  <= ST_SWEEP;
              cnt_r    <= go_clear ? '0 : ADDR_W'(0);
              scroll_r <= go_scroll;
              fill_r   <= go_scroll ? {CH_SPACE, color_nxt} : {CH_NUL, clear_color};
            end
          end
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_char   = out_chr_r;
  assign out_ch.cell_color  = out_clr_r;
  assign out_ch.cursor_col  = out_col_r;
  assign out_ch.cursor_row  = out_row_r;
  assign out_ch.cursor_addr = out_addr_r;

  `TCON_ASSERT(a_col_range, col_r < COL_W'(COLUMNS) && row_r < ROW_W'(LINES), "cursor out of range")
  `TCON_ASSERT(a_read_result, take && cmd.op == OP_READ |=> state_r == ST_READ ##1 out_valid_r, "read result missing")
  `TCON_ASSERT(a_wport_free, wpend_r |-> !take, "write port collision")
  `TCON_ASSERT(a_sweep_end, state_r == ST_SWEEP && cnt_r == ADDR_W'(CELLS - 1) |=> state_r == ST_IDLE, "sweep overrun")
endmodule
